// ----- sv/snfp_pkg.sv -----
// Shared widths, constants and the sideband type for the surface normal unit.
package snfp_pkg;

   // Input coordinate width and derived arithmetic widths.
   localparam int COORD_BITS     = 16;
   localparam int NORM_FRAC_BITS = 14;
   localparam int DW    = COORD_BITS + 1;        // difference A - B
   localparam int PW    = DW + COORD_BITS;       // one cross product term
   localparam int CRW   = PW + 1;                // cross product component
   localparam int POSW  = 6;                     // leading one position
   localparam int AW    = 30;                    // normalized magnitude
   localparam int AMSB  = AW - 1;                // target leading one position
   localparam int SQW   = 2 * AW;                // one square
   localparam int SUMW  = SQW + 2;               // sum of three squares
   localparam int SQRW  = 64;                    // square root remainder
   localparam int RW    = SUMW / 2;              // square root result
   localparam int QW    = NORM_FRAC_BITS + 2;    // quotient bits
   localparam int NUMW  = AW + NORM_FRAC_BITS + 3;
   localparam int OUTW  = 16;
   localparam int LANES = 3;

   // Per transaction data that travels alongside the root and divide pipes.
   typedef struct packed {
      logic                       degen;
      logic [LANES-1:0]           neg;
      logic [LANES-1:0][AW-1:0]   mag_a;
   } snfp_side_type;

endpackage

// ----- sv/surface_normal_from_points_unit.sv -----
// Top level of the surface normal unit: cross product, normalize, root and divide.
//
// Usage. A transaction carries a tangent T and two points A (apex) and B
// (base), all signed Q7.8. It is accepted at a rising edge where start is
// high and busy is low. busy is always low: the unit is fully pipelined and
// takes a new transaction every cycle. The result is the unit vector along
// (A - B) x T in signed Q1.14 on rsp_normal_x/y/z, plus rsp_degenerate when
// the cross product is exactly zero (normal then reads zero).
// Each result appears for exactly one cycle with rsp_valid high; results
// come out in the order the transactions went in.
// The path runs through registered stages of difference, multiply, normalize
// and square-sum, then the square root (one root bit per stage), a register
// forming the dividends and the division (one quotient bit per stage), then
// the output register. Throughput is one transaction per cycle.
// Reset clears all valid bits, so no result appears after reset until new
// transactions are sent. The receiver cannot stall the result channel.
module surface_normal_from_points_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_tangent_x,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_tangent_y,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_tangent_z,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_base_x,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_base_y,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_base_z,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_apex_x,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_apex_y,
   input  logic signed [snfp_pkg::COORD_BITS-1:0] req_apex_z,
   output logic                                 rsp_valid,
   output logic signed [snfp_pkg::OUTW-1:0]       rsp_normal_x,
   output logic signed [snfp_pkg::OUTW-1:0]       rsp_normal_y,
   output logic signed [snfp_pkg::OUTW-1:0]       rsp_normal_z,
   output logic                                 rsp_degenerate
);
   import snfp_pkg::*;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stage 1: difference vector and tangent.
   logic                         v1_ff;
   logic signed [DW-1:0]         d_x_ff, d_y_ff, d_z_ff;
   logic signed [COORD_BITS-1:0] t_x_ff, t_y_ff, t_z_ff;

   // Stage 2: the six products.
   logic                         v2_ff;
   logic signed [PW-1:0]         p_ff [6];

   // Stage 3: cross product magnitudes and signs.
   logic                         v3_ff;
   logic [LANES-1:0][CRW-1:0]    mag_ff;
   logic [LANES-1:0]             neg3_ff;
   logic signed [CRW-1:0]        c_in [LANES];

   // Stage 4: leading one position.
   logic                         v4_ff;
   logic [LANES-1:0][CRW-1:0]    mag4_ff;
   logic [LANES-1:0]             neg4_ff;
   logic                         degen4_ff;
   logic [POSW-1:0]              pos_ff;
   logic [POSW-1:0]              pos_in;
   logic [CRW-1:0]               mag_or;

   // Stage 5 to 7: normalized magnitudes, squares and their sum.
   logic                         v5_ff, v6_ff, v7_ff;
   snfp_side_type                side5_ff, side6_ff, side7_ff;
   snfp_side_type                side5_in;
   logic [LANES-1:0][SQW-1:0]    sq_ff;
   logic [SUMW-1:0]              sum_ff;

   // Root pipe outputs and dividend stage.
   logic                         vr;
   logic [RW-1:0]                root;
   snfp_side_type                side_r;
   logic                         vp_ff;
   logic [RW-1:0]                den_ff;
   logic [LANES-1:0][NUMW-1:0]   num_ff;
   snfp_side_type                sidep_ff;

   // Divider outputs.
   logic                         vq;
   logic [LANES-1:0][QW-1:0]     quo;
   snfp_side_type                side_q;
   logic [LANES-1:0][OUTW-1:0]   norm_in;

   // Valid chain through the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         vp_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         vp_ff <= vr;
      end
   end

   // Stage 1: D = A - B.
   always_ff @(posedge clock) begin
      d_x_ff <= DW'(req_apex_x) - DW'(req_base_x);
      d_y_ff <= DW'(req_apex_y) - DW'(req_base_y);
      d_z_ff <= DW'(req_apex_z) - DW'(req_base_z);
      t_x_ff <= req_tangent_x;
      t_y_ff <= req_tangent_y;
      t_z_ff <= req_tangent_z;
   end

   // Stage 2: cross product terms.
   always_ff @(posedge clock) begin
      p_ff[0] <= PW'(d_y_ff) * PW'(t_z_ff);
      p_ff[1] <= PW'(d_z_ff) * PW'(t_y_ff);
      p_ff[2] <= PW'(d_z_ff) * PW'(t_x_ff);
      p_ff[3] <= PW'(d_x_ff) * PW'(t_z_ff);
      p_ff[4] <= PW'(d_x_ff) * PW'(t_y_ff);
      p_ff[5] <= PW'(d_y_ff) * PW'(t_x_ff);
   end

   // Stage 3: components, split into sign and magnitude.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         c_in[i] = CRW'(p_ff[2*i]) - CRW'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         neg3_ff[i] <= c_in[i][CRW-1];
         mag_ff[i]  <= c_in[i][CRW-1] ? CRW'(-c_in[i]) : CRW'(c_in[i]);
      end
   end

   // Stage 4: the largest magnitude has the same leading one as the OR of all.
   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];

   always_comb begin
      pos_in = '0;
      for (int b = 0; b < CRW; b++) begin
         if (mag_or[b]) begin
            pos_in = POSW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag4_ff   <= mag_ff;
      neg4_ff   <= neg3_ff;
      degen4_ff <= (mag_or == '0);
      pos_ff    <= pos_in;
   end

   // Stage 5: common shift that puts the largest leading one at bit AMSB.
   always_comb begin
      side5_in.degen = degen4_ff;
      side5_in.neg   = neg4_ff;
      for (int i = 0; i < LANES; i++) begin
         if (pos_ff >= POSW'(AMSB)) begin
            side5_in.mag_a[i] = AW'(mag4_ff[i] >> (pos_ff - POSW'(AMSB)));
         end else begin
            side5_in.mag_a[i] = AW'(mag4_ff[i] << (POSW'(AMSB) - pos_ff));
         end
      end
   end

   // Stages 5 to 7: register, square, sum.
   always_ff @(posedge clock) begin
      side5_ff <= side5_in;
      side6_ff <= side5_ff;
      side7_ff <= side6_ff;
      for (int i = 0; i < LANES; i++) begin
         sq_ff[i] <= SQW'(side5_ff.mag_a[i]) * SQW'(side5_ff.mag_a[i]);
      end
      sum_ff <= SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
   end

   snfp_sqrt_pipe u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (v7_ff),
      .sum_i  (sum_ff),
      .side_i (side7_ff),
      .vld_o  (vr),
      .root_o (root),
      .side_o (side_r)
   );

   // Dividends: magnitude scaled to the output fraction plus half the length.
   always_ff @(posedge clock) begin
      den_ff   <= root;
      sidep_ff <= side_r;
      for (int i = 0; i < LANES; i++) begin
         num_ff[i] <= (NUMW'(side_r.mag_a[i]) << NORM_FRAC_BITS) + NUMW'(root >> 1);
      end
   end

   snfp_div_pipe u_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (vp_ff),
      .den_i  (den_ff),
      .num_i  (num_ff),
      .side_i (sidep_ff),
      .vld_o  (vq),
      .quo_o  (quo),
      .side_o (side_q)
   );

   // Clamp to one, apply the sign, and force zero for a degenerate item.
   always_comb begin
      logic [QW-1:0] q;
      for (int i = 0; i < LANES; i++) begin
         q = quo[i];
         if (q > (QW'(1) << NORM_FRAC_BITS)) begin
            q = QW'(1) << NORM_FRAC_BITS;
         end
         if (side_q.degen) begin
            norm_in[i] = '0;
         end else if (side_q.neg[i]) begin
            norm_in[i] = OUTW'(-q);
         end else begin
            norm_in[i] = OUTW'(q);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vq;
      end
   end

   always_ff @(posedge clock) begin
      rsp_normal_x   <= norm_in[0];
      rsp_normal_y   <= norm_in[1];
      rsp_normal_z   <= norm_in[2];
      rsp_degenerate <= side_q.degen;
   end

endmodule

// ----- sv/snfp_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per register stage.
module snfp_sqrt_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      vld_i,
   input  logic [snfp_pkg::SUMW-1:0] sum_i,
   input  snfp_pkg::snfp_side_type   side_i,
   output logic                      vld_o,
   output logic [snfp_pkg::RW-1:0]   root_o,
   output snfp_pkg::snfp_side_type   side_o
);
   import snfp_pkg::*;

   logic [SQRW-1:0] rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic            vld_ff  [RW];
   snfp_side_type   side_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      localparam int BIT = RW - 1 - j;
      logic [SQRW-1:0] rem_prev;
      logic [SQRW-1:0] trial;
      logic [RW-1:0]   root_prev;
      logic            vld_prev;
      snfp_side_type   side_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = SQRW'(sum_i);
         assign root_prev = '0;
         assign vld_prev  = vld_i;
         assign side_prev = side_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign vld_prev  = vld_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // Growing the root by this bit costs (2*root + 2^BIT) * 2^BIT.
      assign trial = ((SQRW'(root_prev) << 1) + (SQRW'(1) << BIT)) << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_prev;
         end
      end

      // Accept the bit when the remainder covers its cost.
      always_ff @(posedge clock) begin
         side_ff[j] <= side_prev;
         if (rem_prev >= trial) begin
            rem_ff[j]  <= rem_prev - trial;
            root_ff[j] <= root_prev | (RW'(1) << BIT);
         end else begin
            rem_ff[j]  <= rem_prev;
            root_ff[j] <= root_prev;
         end
      end
   end

   assign vld_o  = vld_ff[RW-1];
   assign root_o = root_ff[RW-1];
   assign side_o = side_ff[RW-1];

endmodule

// ----- sv/snfp_div_pipe.sv -----
// Pipelined restoring divider, three lanes sharing one divisor.
module snfp_div_pipe (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          vld_i,
   input  logic [snfp_pkg::RW-1:0]                       den_i,
   input  logic [snfp_pkg::LANES-1:0][snfp_pkg::NUMW-1:0] num_i,
   input  snfp_pkg::snfp_side_type                       side_i,
   output logic                                          vld_o,
   output logic [snfp_pkg::LANES-1:0][snfp_pkg::QW-1:0]   quo_o,
   output snfp_pkg::snfp_side_type                       side_o
);
   import snfp_pkg::*;

   logic [LANES-1:0][NUMW-1:0] rem_ff  [QW];
   logic [LANES-1:0][QW-1:0]   quo_ff  [QW];
   logic [RW-1:0]              den_ff  [QW];
   logic                       vld_ff  [QW];
   snfp_side_type              side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int BIT = QW - 1 - k;
      logic [LANES-1:0][NUMW-1:0] rem_prev;
      logic [LANES-1:0][QW-1:0]   quo_prev;
      logic [RW-1:0]              den_prev;
      logic                       vld_prev;
      snfp_side_type              side_prev;
      logic [NUMW-1:0]            den_sh;
      logic [LANES-1:0][NUMW-1:0] rem_in;
      logic [LANES-1:0][QW-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign rem_prev  = num_i;
         assign quo_prev  = '0;
         assign den_prev  = den_i;
         assign vld_prev  = vld_i;
         assign side_prev = side_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign den_sh = NUMW'(den_prev) << BIT;

      // Each lane subtracts the shifted divisor when it fits.
      always_comb begin
         for (int i = 0; i < LANES; i++) begin
            if (rem_prev[i] >= den_sh) begin
               rem_in[i] = rem_prev[i] - den_sh;
               quo_in[i] = quo_prev[i] | (QW'(1) << BIT);
            end else begin
               rem_in[i] = rem_prev[i];
               quo_in[i] = quo_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         den_ff[k]  <= den_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign vld_o  = vld_ff[QW-1];
   assign quo_o  = quo_ff[QW-1];
   assign side_o = side_ff[QW-1];

endmodule
